// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check outside reset only.
`define TGL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check at every edge, reset included.
`define TGL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: design/tglad_pkg.sv
// ----------------------------------------------------------------------------
// tglad_pkg
// Beat types, register map and fixed-point helpers of the 4D box fold.
// ----------------------------------------------------------------------------
package tglad_pkg;

  localparam int unsigned NumAxes  = 4;
  localparam int unsigned NumMul   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegEnableMask  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFoldLimits  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowsAbc  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWindowsDef  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScales14    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScaleFive   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegColorFacts  = 3'd6;

  // Enable mask bit positions
  localparam int unsigned EnColor    = 4;
  localparam int unsigned EnWeighted = 5;
  localparam int unsigned EnMulLo    = 6;

  localparam logic signed [63:0] S32Max = 64'sd2147483647;
  localparam logic signed [63:0] S32Min = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
    logic [7:0]         iteration;
    logic signed [31:0] color_in;
    logic [31:0]        deriv_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic signed [31:0] color_out;
    logic [31:0]        deriv_out;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic [10:0] enable_mask;
    logic [63:0] fold_limits;
    logic [47:0] windows_abc;
    logic [47:0] windows_def;
    logic [63:0] scales_one_to_four;
    logic [15:0] scale_five;
    logic [63:0] color_factors;
  } cfg_t;

  // Point state carried down the multiplier chain
  typedef struct packed {
    logic [NumAxes-1:0][31:0] v;
    logic [31:0]              color;
    logic [31:0]              deriv;
    logic [NumMul-1:0]        mul_en;
    logic                     sat;
  } point_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clamp_t;

  function automatic clamp_t clamp_s32(input logic signed [63:0] x);
    clamp_t r;
    r.sat = 1'b0;
    r.val = x[31:0];
    if (x > S32Max) begin
      r.sat = 1'b1;
      r.val = S32Max[31:0];
    end else if (x < S32Min) begin
      r.sat = 1'b1;
      r.val = S32Min[31:0];
    end
    return r;
  endfunction

  // Round a product with 8 extra fraction bits: floor((p + 128) / 256)
  function automatic logic signed [63:0] round_q8(input logic signed [63:0] p);
    return (p + 64'sd128) >>> 8;
  endfunction

  function automatic logic signed [15:0] q88_slot(input logic [63:0] pk,
                                                  input logic [1:0] slot);
    return pk[16*slot +: 16];
  endfunction

endpackage

// File: design/tglad_fold.sv
// ----------------------------------------------------------------------------
// tglad_fold
// Four-stage fold and color section: window decode, per-axis box fold with
// clamp, weighted color products, then color sum and clamp.
// ----------------------------------------------------------------------------
module tglad_fold #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  tglad_pkg::cfg_t   cfg_i,
  input  tglad_pkg::in_beat_t in_i,
  output tglad_pkg::point_t pt_o
);

  localparam int unsigned Sh    = FRAC_BITS - 8;
  localparam int unsigned NA    = tglad_pkg::NumAxes;
  localparam int unsigned NM    = tglad_pkg::NumMul;
  localparam int unsigned SumW  = 34;
  localparam int unsigned FoldW = 36;
  localparam int unsigned DiffW = 34;
  localparam int unsigned ProdW = 50;
  localparam int unsigned TermW = 42;
  localparam int unsigned ColW  = 46;

  // Stage A: sums and differences with the limits
  logic signed [31:0]   vin   [NA];
  logic signed [31:0]   lim   [NA];
  logic signed [31:0]   fac_w [NA];
  logic [5:0]           win;
  logic [95:0]          win_bits;
  logic signed [31:0]   va_q  [NA];
  logic signed [SumW-1:0] suma_q [NA];
  logic signed [SumW-1:0] difa_q [NA];
  logic [NA-1:0]        fold_on_q;
  logic [NM-1:0]        mul_en_a_q;
  logic [31:0]          color_a_q;
  logic [31:0]          deriv_a_q;

  always_comb begin
    vin[0] = in_i.in_x;
    vin[1] = in_i.in_y;
    vin[2] = in_i.in_z;
    vin[3] = in_i.in_w;
    for (int a = 0; a < NA; a++) begin
      lim[a]   = 32'(tglad_pkg::q88_slot(cfg_i.fold_limits, 2'(a))) <<< Sh;
      fac_w[a] = 32'(tglad_pkg::q88_slot(cfg_i.color_factors, 2'(a))) <<< Sh;
    end
    win_bits = {cfg_i.windows_def, cfg_i.windows_abc};
    for (int w = 0; w < 6; w++) begin
      win[w] = (in_i.iteration >= win_bits[16*w +: 8]) &&
               (in_i.iteration <  win_bits[16*w+8 +: 8]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NA; a++) begin
        va_q[a]   <= vin[a];
        suma_q[a] <= SumW'(vin[a]) + SumW'(lim[a]);
        difa_q[a] <= SumW'(vin[a]) - SumW'(lim[a]);
      end
      fold_on_q  <= cfg_i.enable_mask[NA-1:0] & win[NA-1:0];
      // multiplier k uses window k+1
      mul_en_a_q <= cfg_i.enable_mask[tglad_pkg::EnMulLo +: NM] & win[NM:1];
      color_a_q  <= in_i.color_in;
      deriv_a_q  <= in_i.deriv_in;
    end
  end

  // Stage B: |v+L| - |v-L| - v, clamp
  logic signed [FoldW-1:0] fold_v [NA];
  logic signed [SumW-1:0]  abs_s  [NA];
  logic signed [SumW-1:0]  abs_d  [NA];
  tglad_pkg::clamp_t       fold_c [NA];
  logic signed [31:0]      vb_q   [NA];
  logic [NA-1:0]           chg_b_q;
  logic                    sat_b_q;
  logic [NM-1:0]           mul_en_b_q;
  logic [31:0]             color_b_q;
  logic [31:0]             deriv_b_q;
  logic                    sat_b;

  always_comb begin
    sat_b = 1'b0;
    for (int a = 0; a < NA; a++) begin
      abs_s[a]  = (suma_q[a] < 0) ? -suma_q[a] : suma_q[a];
      abs_d[a]  = (difa_q[a] < 0) ? -difa_q[a] : difa_q[a];
      fold_v[a] = FoldW'(abs_s[a]) - FoldW'(abs_d[a]) - FoldW'(va_q[a]);
      fold_c[a] = tglad_pkg::clamp_s32(64'(fold_v[a]));
      sat_b     = sat_b | (fold_on_q[a] & fold_c[a].sat);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NA; a++) begin
        vb_q[a]    <= fold_on_q[a] ? signed'(fold_c[a].val) : va_q[a];
        chg_b_q[a] <= fold_on_q[a] && (fold_c[a].val != va_q[a]);
      end
      sat_b_q    <= sat_b;
      mul_en_b_q <= mul_en_a_q;
      color_b_q  <= color_a_q;
      deriv_b_q  <= deriv_a_q;
    end
  end

  // Stage C: weighted color products factor * (|v| - L)
  logic signed [DiffW-1:0] vx    [NA];
  logic signed [DiffW-1:0] dw    [NA];
  logic signed [15:0]      fac   [NA];
  logic signed [ProdW-1:0] prod  [NA];
  logic signed [31:0]      vc_q  [NA];
  logic signed [ProdW-1:0] prod_q [NA];
  logic [NA-1:0]           chg_c_q;
  logic                    sat_c_q;
  logic [NM-1:0]           mul_en_c_q;
  logic [31:0]             color_c_q;
  logic [31:0]             deriv_c_q;

  always_comb begin
    for (int a = 0; a < NA; a++) begin
      vx[a]   = DiffW'(vb_q[a]);
      dw[a]   = ((vx[a] < 0) ? -vx[a] : vx[a]) - DiffW'(lim[a]);
      fac[a]  = tglad_pkg::q88_slot(cfg_i.color_factors, 2'(a));
      prod[a] = fac[a] * dw[a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < NA; a++) begin
        vc_q[a]   <= vb_q[a];
        prod_q[a] <= prod[a];
      end
      chg_c_q    <= chg_b_q;
      sat_c_q    <= sat_b_q;
      mul_en_c_q <= mul_en_b_q;
      color_c_q  <= color_b_q;
      deriv_c_q  <= deriv_b_q;
    end
  end

  // Stage D: color sum and clamp
  logic signed [63:0]     rnd  [NA];
  logic signed [TermW-1:0] term [NA];
  logic signed [ColW-1:0] col_sum;
  tglad_pkg::clamp_t      col_c;
  tglad_pkg::point_t      pt_d;
  tglad_pkg::point_t      pt_q;

  always_comb begin
    col_sum = ColW'(signed'(color_c_q));
    for (int a = 0; a < NA; a++) begin
      rnd[a] = tglad_pkg::round_q8(64'(prod_q[a]));
      if (!chg_c_q[a]) begin
        term[a] = '0;
      end else if (cfg_i.enable_mask[tglad_pkg::EnWeighted]) begin
        term[a] = rnd[a][TermW-1:0];
      end else begin
        term[a] = TermW'(fac_w[a]);
      end
      col_sum = col_sum + ColW'(term[a]);
    end
    col_c = tglad_pkg::clamp_s32(64'(col_sum));

    pt_d.v      = {vc_q[3], vc_q[2], vc_q[1], vc_q[0]};
    pt_d.deriv  = deriv_c_q;
    pt_d.mul_en = mul_en_c_q;
    pt_d.color  = color_c_q;
    pt_d.sat    = sat_c_q;
    if (cfg_i.enable_mask[tglad_pkg::EnColor]) begin
      pt_d.color = col_c.val;
      pt_d.sat   = sat_c_q | col_c.sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q <= pt_d;
    end
  end

  assign pt_o = pt_q;

endmodule

// File: design/tglad_scale.sv
// ----------------------------------------------------------------------------
// tglad_scale
// One uniform scaling step in two stages: products of the four axes by s and
// of the derivative by |s|, then rounding and clamping.
// ----------------------------------------------------------------------------
module tglad_scale (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] scale_i,
  input  logic               act_i,
  input  tglad_pkg::point_t  pt_i,
  output tglad_pkg::point_t  pt_o
);

  localparam int unsigned NA    = tglad_pkg::NumAxes;
  localparam int unsigned ProdW = 48;

  logic signed [16:0]      s_ext;
  logic [15:0]             s_mag;
  logic signed [31:0]      v_in   [NA];
  logic signed [ProdW-1:0] prod_v [NA];
  logic [ProdW-1:0]        prod_d;

  always_comb begin
    s_ext = 17'(scale_i);
    // -32768 gives a magnitude of 32768, still fits 16 unsigned bits
    s_mag = (s_ext < 0) ? 16'(-s_ext) : 16'(s_ext);
    for (int a = 0; a < NA; a++) begin
      v_in[a]   = pt_i.v[a];
      prod_v[a] = v_in[a] * scale_i;
    end
    prod_d = pt_i.deriv * s_mag;
  end

  // Product stage
  tglad_pkg::point_t       pp_q;
  logic                    act_q;
  logic signed [ProdW-1:0] pv_q [NA];
  logic [ProdW-1:0]        pd_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pt_i;
      act_q <= act_i;
      for (int a = 0; a < NA; a++) begin
        pv_q[a] <= prod_v[a];
      end
      pd_q <= prod_d;
    end
  end

  // Round and clamp stage
  tglad_pkg::clamp_t  vc [NA];
  logic signed [63:0] rd;
  tglad_pkg::point_t  pr_d;
  tglad_pkg::point_t  pr_q;

  always_comb begin
    pr_d = pp_q;
    rd   = tglad_pkg::round_q8(64'(pd_q));
    for (int a = 0; a < NA; a++) begin
      vc[a] = tglad_pkg::clamp_s32(tglad_pkg::round_q8(64'(pv_q[a])));
    end
    if (act_q) begin
      for (int a = 0; a < NA; a++) begin
        pr_d.v[a] = vc[a].val;
        pr_d.sat  = pr_d.sat | vc[a].sat;
      end
      if (rd[63:32] != '0) begin
        pr_d.deriv = '1;
        pr_d.sat   = 1'b1;
      end else begin
        pr_d.deriv = rd[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
    end
  end

  assign pt_o = pr_q;

endmodule

// File: design/tglad_fold_4d_transform.sv
// ----------------------------------------------------------------------------
// tglad_fold_4d_transform
// Four-axis box fold with color update and five gated uniform scalings.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid_i/in_ready_o/in_data_i carry one 4D point per beat, together with
//   its iteration, color and derivative. out_valid_o/out_ready_i/out_data_o
//   return one result beat per input beat, in order.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write one register per cycle; write only
//   while no beat is in flight. Indexes above the register list are ignored.
// Pipeline: 4 fold/color stages, then a product stage and a round/clamp stage
//   for each of 5 multipliers.
// Throughput: one beat per cycle unless the output stalls; every stage holds
//   one point and the whole pipe advances together.
// Reset: all stage valid bits clear and the registers take their defaults
//   (folds x..w on, windows 0..254, unit scales, zero limits and factors).
// Stall: while out_valid_o is high and out_ready_i low the pipe freezes and
//   in_ready_o drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tglad_fold_4d_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  tglad_pkg::in_beat_t                  in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output tglad_pkg::out_beat_t                 out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [tglad_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [tglad_pkg::CfgDataW-1:0]       cfg_wdata_i
);

  localparam int unsigned NM     = tglad_pkg::NumMul;
  localparam int unsigned NumStg = 4 + 2 * NM;

  // Configuration registers
  tglad_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mask        <= 11'd15;
      cfg_q.fold_limits        <= '0;
      cfg_q.windows_abc        <= 48'hFF00_FF00_FF00;
      cfg_q.windows_def        <= 48'hFF00_FF00_FF00;
      cfg_q.scales_one_to_four <= 64'h0100_0100_0100_0100;
      cfg_q.scale_five         <= 16'h0100;
      cfg_q.color_factors      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tglad_pkg::RegEnableMask: cfg_q.enable_mask        <= cfg_wdata_i[10:0];
        tglad_pkg::RegFoldLimits: cfg_q.fold_limits        <= cfg_wdata_i;
        tglad_pkg::RegWindowsAbc: cfg_q.windows_abc        <= cfg_wdata_i[47:0];
        tglad_pkg::RegWindowsDef: cfg_q.windows_def        <= cfg_wdata_i[47:0];
        tglad_pkg::RegScales14:   cfg_q.scales_one_to_four <= cfg_wdata_i;
        tglad_pkg::RegScaleFive:  cfg_q.scale_five         <= cfg_wdata_i[15:0];
        tglad_pkg::RegColorFacts: cfg_q.color_factors      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipe control: one enable for every stage
  logic              adv;
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] vld_d;

  assign adv        = !vld_q[NumStg-1] || out_ready_i;
  assign in_ready_o = adv;
  assign vld_d      = {vld_q[NumStg-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // Datapath
  tglad_pkg::point_t  pt [NM+1];
  logic signed [15:0] scl [NM];

  always_comb begin
    for (int k = 0; k < NM - 1; k++) begin
      scl[k] = cfg_q.scales_one_to_four[16*k +: 16];
    end
    scl[NM-1] = cfg_q.scale_five;
  end

  tglad_fold #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fold (
    .clk_i (clk_i),
    .en_i  (adv),
    .cfg_i (cfg_q),
    .in_i  (in_data_i),
    .pt_o  (pt[0])
  );

  for (genvar k = 0; k < NM; k++) begin : g_scale
    tglad_scale u_scale (
      .clk_i   (clk_i),
      .en_i    (adv),
      .scale_i (scl[k]),
      .act_i   (pt[k].mul_en[k]),
      .pt_i    (pt[k]),
      .pt_o    (pt[k+1])
    );
  end

  assign out_valid_o          = vld_q[NumStg-1];
  assign out_data_o.out_x     = pt[NM].v[0];
  assign out_data_o.out_y     = pt[NM].v[1];
  assign out_data_o.out_z     = pt[NM].v[2];
  assign out_data_o.out_w     = pt[NM].v[3];
  assign out_data_o.color_out = pt[NM].color;
  assign out_data_o.deriv_out = pt[NM].deriv;
  assign out_data_o.saturated = pt[NM].sat;

  // Checks
  `TGL_ASSERT_RST(a_rst_clears, !rst_ni |=> (vld_q == '0), "valid bits not cleared in reset")
  `TGL_ASSERT(a_stall_freezes, (out_valid_o && !out_ready_i) |=> $stable(vld_q), "pipe moved while stalled")
  `TGL_ASSERT(a_no_accept_in_stall, (in_valid_i && in_ready_o) |-> (!out_valid_o || out_ready_i), "beat taken during stall")
  `TGL_ASSERT(a_bubble_follows, (out_valid_o && out_ready_i && !vld_q[NumStg-2]) |=> !out_valid_o, "beat invented after bubble")

endmodule

// File: tb/tglad_fold_4d_transform_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tglad_fold_4d_transform_tb
// Self-checking bench for the 4D box fold: a local fixed-point predictor
// tracks the register file and computes each result beat. Directed points
// cover the saturating corners, windows, weighted color and register write
// rules. Random setups with bursty input and stalling output follow.
// ----------------------------------------------------------------------------
module tglad_fold_4d_transform_tb;

  localparam int unsigned FRAC_BITS     = 16;
  localparam int          PipeLat       = 14;
  localparam int          CycleLimit    = 600000;
  localparam int          NumPhases     = 12;
  localparam int          ItemsPerPhase = 128;

  localparam logic [tglad_pkg::CfgIdxW-1:0] RegUnused = 3'd7;

  localparam longint MaxS32    = 64'sd2147483647;
  localparam longint MinS32    = -64'sd2147483648;
  localparam longint DerivMax  = 64'sd4294967295;
  localparam longint FracScale = longint'(1) << (FRAC_BITS - 8);

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  tglad_pkg::in_beat_t            in_data_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  tglad_pkg::out_beat_t           out_data_o;
  logic                           cfg_we_i    = 1'b0;
  logic [tglad_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [tglad_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  tglad_pkg::cfg_t       cfg_shadow;
  tglad_pkg::out_beat_t  expected_q[$];

  int  err_count    = 0;
  int  points_sent  = 0;
  int  results_seen = 0;
  int  sat_seen     = 0;
  int  cfg_writes   = 0;
  int  cycle_count  = 0;

  // sender burst shaping
  bit  gaps_on    = 1'b1;
  int  burst_left = 0;

  // receiver stall control: bump hold_token to request a hold of out_ready_i sized by hold_len
  int          hold_len   = 0;
  int          hold_token = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  logic [15:0] ready_pat  = 16'hFFFF;
  int          pat_age    = 0;

  tglad_fold_4d_transform #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[tglad_fold_4d_transform] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint mag(input longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic bit over32(input longint x);
    return (x > MaxS32) || (x < MinS32);
  endfunction

  function automatic longint clip32(input longint x);
    if (x > MaxS32) return MaxS32;
    if (x < MinS32) return MinS32;
    return x;
  endfunction

  // drop 8 fraction bits, round half up
  function automatic longint rnd8(input longint p);
    longint q;
    q = p + 128;
    if (q >= 0) return q / 256;
    return -((-q + 255) / 256);
  endfunction

  function automatic longint q88_at(input logic [63:0] pk, input int slot);
    logic signed [15:0] f;
    f = pk[16*slot +: 16];
    return longint'(f);
  endfunction

  function automatic bit win_open(input int w, input logic [7:0] it);
    logic [47:0] wr;
    logic [15:0] fld;
    wr  = (w < 3) ? cfg_shadow.windows_abc : cfg_shadow.windows_def;
    fld = wr[16*(w%3) +: 16];
    return (it >= fld[7:0]) && (it < fld[15:8]);
  endfunction

  function automatic tglad_pkg::out_beat_t fold_transform(input tglad_pkg::in_beat_t p);
    longint               v[4];
    longint               orig[4];
    longint               lim[4];
    longint               col;
    longint               der;
    longint               s;
    longint               f;
    logic                 sat;
    tglad_pkg::out_beat_t r;
    v[0] = longint'($signed(p.in_x));
    v[1] = longint'($signed(p.in_y));
    v[2] = longint'($signed(p.in_z));
    v[3] = longint'($signed(p.in_w));
    col  = longint'($signed(p.color_in));
    der  = longint'(p.deriv_in);
    sat  = 1'b0;
    for (int a = 0; a < tglad_pkg::NumAxes; a++) begin
      orig[a] = v[a];
      lim[a]  = q88_at(cfg_shadow.fold_limits, a) * FracScale;
      if (cfg_shadow.enable_mask[a] && win_open(a, p.iteration)) begin
        f    = mag(v[a] + lim[a]) - mag(v[a] - lim[a]) - v[a];
        sat |= over32(f);
        v[a] = clip32(f);
      end
    end
    if (cfg_shadow.enable_mask[tglad_pkg::EnColor]) begin
      for (int a = 0; a < tglad_pkg::NumAxes; a++) begin
        if (v[a] != orig[a]) begin
          if (cfg_shadow.enable_mask[tglad_pkg::EnWeighted])
            col += rnd8(q88_at(cfg_shadow.color_factors, a) * (mag(v[a]) - lim[a]));
          else
            col += q88_at(cfg_shadow.color_factors, a) * FracScale;
        end
      end
      sat |= over32(col);
      col  = clip32(col);
    end
    for (int k = 0; k < tglad_pkg::NumMul; k++) begin
      if (cfg_shadow.enable_mask[tglad_pkg::EnMulLo + k] && win_open(k + 1, p.iteration)) begin
        s = (k < 4) ? q88_at(cfg_shadow.scales_one_to_four, k)
                    : longint'($signed(cfg_shadow.scale_five));
        for (int a = 0; a < tglad_pkg::NumAxes; a++) begin
          f    = rnd8(v[a] * s);
          sat |= over32(f);
          v[a] = clip32(f);
        end
        der = rnd8(der * mag(s));
        if (der > DerivMax) begin
          der = DerivMax;
          sat = 1'b1;
        end
      end
    end
    r.out_x     = v[0][31:0];
    r.out_y     = v[1][31:0];
    r.out_z     = v[2][31:0];
    r.out_w     = v[3][31:0];
    r.color_out = col[31:0];
    r.deriv_out = der[31:0];
    r.saturated = sat;
    return r;
  endfunction

  // ------------------------------------------------------------------ checker

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    tglad_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no point outstanding");
        err_count++;
      end else begin
        want = expected_q.pop_front();
        check_field("out_x", want.out_x, out_data_o.out_x);
        check_field("out_y", want.out_y, out_data_o.out_y);
        check_field("out_z", want.out_z, out_data_o.out_z);
        check_field("out_w", want.out_w, out_data_o.out_w);
        check_field("color_out", want.color_out, out_data_o.color_out);
        check_field("deriv_out", want.deriv_out, out_data_o.deriv_out);
        check_field("saturated", {31'd0, want.saturated}, {31'd0, out_data_o.saturated});
        results_seen++;
        if (want.saturated) sat_seen++;
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  always @(negedge clk_i) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= hold_len;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (pat_age == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= 16'hFFFF;
        1:       ready_pat <= 16'($urandom()) | 16'h0001;
        default: ready_pat <= 16'($urandom()) | 16'($urandom());
      endcase
      pat_age <= int'($urandom_range(20, 120));
    end else begin
      pat_age <= pat_age - 1;
    end
    out_ready_i <= (hold_left == 0) && (hold_token == hold_seen) && ready_pat[pat_age[3:0]];
  end

  // ------------------------------------------------------------------- driver

  task automatic send_point(input tglad_pkg::in_beat_t p);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = int'($urandom_range(1, 40));
        gap        = int'($urandom_range(1, 8));
      end
      burst_left--;
    end
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(fold_transform(p));
    points_sent++;
  endtask

  // hold input until every result is back, then let the pipe settle
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tglad_pkg::CfgIdxW-1:0] idx,
                           input logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tglad_pkg::RegEnableMask: cfg_shadow.enable_mask        = data[10:0];
      tglad_pkg::RegFoldLimits: cfg_shadow.fold_limits        = data;
      tglad_pkg::RegWindowsAbc: cfg_shadow.windows_abc        = data[47:0];
      tglad_pkg::RegWindowsDef: cfg_shadow.windows_def        = data[47:0];
      tglad_pkg::RegScales14:   cfg_shadow.scales_one_to_four = data;
      tglad_pkg::RegScaleFive:  cfg_shadow.scale_five         = data[15:0];
      tglad_pkg::RegColorFacts: cfg_shadow.color_factors      = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- generators

  function automatic tglad_pkg::in_beat_t mk_point(
      input logic [31:0] x, input logic [31:0] y,
      input logic [31:0] z, input logic [31:0] w,
      input logic [7:0] it, input logic [31:0] col,
      input logic [31:0] der);
    tglad_pkg::in_beat_t p;
    p.in_x      = x;
    p.in_y      = y;
    p.in_z      = z;
    p.in_w      = w;
    p.iteration = it;
    p.color_in  = col;
    p.deriv_in  = der;
    return p;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0:       w = 32'h7FFF_FFFF;
      1:       w = 32'h8000_0000;
      2:       w = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      3, 4:    w = $urandom();
      default: begin
        w = $urandom_range(0, 1048576);
        w = w - 32'd524288;
      end
    endcase
    return w;
  endfunction

  function automatic tglad_pkg::in_beat_t rand_point();
    logic [7:0]  it;
    logic [31:0] der;
    if ($urandom_range(0, 7) == 0)
      it = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    else
      it = 8'($urandom_range(0, 255));
    der = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0004_0000);
    return mk_point(rand_word(), rand_word(), rand_word(), rand_word(), it,
                    rand_word(), der);
  endfunction

  function automatic logic [15:0] rand_q88();
    logic [15:0] q;
    case ($urandom_range(0, 7))
      0:       q = 16'h7FFF;
      1:       q = 16'h8000;
      2:       q = 16'h0000;
      3:       q = 16'($urandom());
      default: begin
        q = 16'($urandom_range(0, 1536));
        q = q - 16'd768;
      end
    endcase
    return q;
  endfunction

  // mostly 0.5..2.0 in either sign, so five stages rarely all clamp
  function automatic logic [15:0] rand_scale();
    logic [15:0] q;
    case ($urandom_range(0, 9))
      0:       q = 16'h7FFF;
      1:       q = 16'h8000;
      2:       q = 16'h0000;
      3:       q = 16'h0100;
      default: begin
        q = 16'($urandom_range(128, 512));
        if ($urandom_range(0, 1) != 0) q = -q;
      end
    endcase
    return q;
  endfunction

  function automatic logic [15:0] rand_window();
    logic [7:0] st;
    logic [7:0] sp;
    case ($urandom_range(0, 5))
      0: begin
        st = 8'h00;
        sp = 8'hFF;
      end
      1: begin
        st = 8'($urandom_range(0, 255));
        sp = 8'($urandom_range(0, st));
      end
      default: begin
        st = 8'($urandom_range(0, 200));
        sp = 8'($urandom_range(st + 1, 255));
      end
    endcase
    return {sp, st};
  endfunction

  // phase 0 drives every register to its top corner, phase 1 clears them
  function automatic logic [63:0] pick_word(input int phase, input logic [63:0] top,
                                            input logic [63:0] rnd);
    if (phase == 0) return top;
    if (phase == 1) return 64'h0;
    return rnd;
  endfunction

  task automatic load_random_setup(input int phase);
    logic [47:0] junk;
    junk = 48'({$urandom(), $urandom()});
    write_reg(tglad_pkg::RegEnableMask,
              pick_word(phase, 64'h7FF, {$urandom(), $urandom()}));
    write_reg(tglad_pkg::RegFoldLimits,
              pick_word(phase, {4{16'h7FFF}},
                        {rand_q88(), rand_q88(), rand_q88(), rand_q88()}));
    write_reg(tglad_pkg::RegWindowsAbc,
              pick_word(phase, 64'hFF00_FF00_FF00,
                        {rand_q88(), rand_window(), rand_window(), rand_window()}));
    write_reg(tglad_pkg::RegWindowsDef,
              pick_word(phase, 64'hFF00_FF00_FF00,
                        {rand_q88(), rand_window(), rand_window(), rand_window()}));
    write_reg(tglad_pkg::RegScales14,
              pick_word(phase, {4{16'h7FFF}},
                        {rand_scale(), rand_scale(), rand_scale(), rand_scale()}));
    write_reg(tglad_pkg::RegScaleFive, pick_word(phase, 64'h7FFF, {junk, rand_scale()}));
    write_reg(tglad_pkg::RegColorFacts,
              pick_word(phase, {4{16'h8000}},
                        {rand_q88(), rand_q88(), rand_q88(), rand_q88()}));
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_point(mk_point(32'h0, 32'h0, 32'h0, 32'h0, 8'd0, 32'h0, 32'h0));
    send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 8'd254,
                        32'h7FFF_FFFF, 32'hFFFF_FFFF));
    // iteration 255 sits outside every window: point passes unchanged
    send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 8'd255,
                        32'h8000_0000, 32'hFFFF_FFFF));
    send_point(mk_point(32'h0001_0000, 32'hFFFF_8000, 32'h0000_0001, 32'h8000_0001,
                        8'd100, 32'h0000_1234, 32'h0001_0000));
  endtask

  task automatic test_fold_and_color();
    tglad_pkg::in_beat_t pa;
    pa = mk_point(32'h0003_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd7,
                  32'h0001_0000, 32'h0002_0000);
    drain_pipe();
    write_reg(tglad_pkg::RegFoldLimits, 64'h8000_7FFF_FE00_0100);
    write_reg(tglad_pkg::RegColorFacts, 64'hFF00_0100_8000_7FFF);
    write_reg(tglad_pkg::RegEnableMask, 64'h01F);
    send_point(pa);
    send_point(mk_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                        8'd7, 32'h7FFF_FFFF, 32'h0));
    drain_pipe();
    write_reg(tglad_pkg::RegEnableMask, 64'h03F);
    send_point(pa);
    send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        8'd0, 32'h8000_0000, 32'h0));
    // weighted bit alone leaves color untouched
    drain_pipe();
    write_reg(tglad_pkg::RegEnableMask, 64'h02F);
    send_point(pa);
    // x window 5..9, y window empty, z window full
    drain_pipe();
    write_reg(tglad_pkg::RegWindowsAbc, 64'hFF00_0A14_0A05);
    write_reg(tglad_pkg::RegEnableMask, 64'h01F);
    send_point(mk_point(32'h0003_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        8'd4, 32'h0, 32'h0));
    send_point(mk_point(32'h0003_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        8'd5, 32'h0, 32'h0));
    send_point(mk_point(32'h0003_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        8'd9, 32'h0, 32'h0));
    send_point(mk_point(32'h0003_0000, 32'hFFFB_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                        8'd10, 32'h0, 32'h0));
  endtask

  task automatic test_multipliers();
    drain_pipe();
    write_reg(tglad_pkg::RegWindowsAbc, 64'hFF00_FF00_FF00);
    write_reg(tglad_pkg::RegWindowsDef, 64'hFF00_FF00_FF00);
    write_reg(tglad_pkg::RegScales14, 64'h8000_0080_FF00_0200);
    write_reg(tglad_pkg::RegScaleFive, 64'h7FFF);
    write_reg(tglad_pkg::RegEnableMask, 64'h7C0);
    send_point(mk_point(32'h0000_0100, 32'hFFFF_FF00, 32'h0, 32'h0000_0001, 8'd3,
                        32'h0, 32'hFFFF_FFFF));
    send_point(mk_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                        8'd3, 32'h0, 32'h0001_0000));
    // most negative scale: derivative grows by 128.0
    drain_pipe();
    write_reg(tglad_pkg::RegScales14, {4{16'h0100}});
    write_reg(tglad_pkg::RegScaleFive, 64'h8000);
    write_reg(tglad_pkg::RegEnableMask, 64'h7FF);
    send_point(mk_point(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0100,
                        8'd200, 32'h0, 32'h0000_0100));
    send_point(mk_point(32'h0000_0080, 32'hFFFF_FF80, 32'h0000_007F, 32'h0,
                        8'd1, 32'h7FFF_FFFF, 32'h0001_FFFF));
    // D empty, E only at iteration 3, F full
    drain_pipe();
    write_reg(tglad_pkg::RegWindowsDef, 64'hFF00_0403_0505);
    send_point(mk_point(32'h0000_0100, 32'h0, 32'h0, 32'h0, 8'd3, 32'h0, 32'h0000_0100));
    send_point(mk_point(32'h0000_0100, 32'h0, 32'h0, 32'h0, 8'd4, 32'h0, 32'h0000_0100));
  endtask

  task automatic test_register_writes();
    drain_pipe();
    // unmapped index and bits above each register are dropped
    write_reg(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tglad_pkg::RegEnableMask, 64'hFFFF_FFFF_FFFF_F81F);
    write_reg(tglad_pkg::RegWindowsAbc, 64'hFFFF_FF00_FF00_FF00);
    write_reg(tglad_pkg::RegWindowsDef, 64'hFFFF_FF00_FF00_FF00);
    write_reg(tglad_pkg::RegScaleFive, 64'hFFFF_FFFF_FFFF_0100);
    send_point(mk_point(32'h0005_0000, 32'hFFFD_0000, 32'h0000_0001, 32'h7FFF_0000,
                        8'd42, 32'h0000_1000, 32'h0001_0000));
    send_point(mk_point(32'hFFF0_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_4000,
                        8'd42, 32'hFFFF_F000, 32'h0001_0000));
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_pipe();
      load_random_setup(phase);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < ItemsPerPhase; n++) send_point(rand_point());
    end
    gaps_on = 1'b1;
  endtask

  // long output stall while input keeps coming: pipe fills and in_ready drops
  task automatic test_backpressure();
    drain_pipe();
    load_random_setup(2);
    gaps_on    = 1'b0;
    hold_len   = 300;
    hold_token = hold_token + 1;
    for (int n = 0; n < 150; n++) send_point(rand_point());
    gaps_on = 1'b1;
  endtask

  initial begin
    cfg_shadow.enable_mask        = 11'd15;
    cfg_shadow.fold_limits        = 64'h0;
    cfg_shadow.windows_abc        = 48'hFF00_FF00_FF00;
    cfg_shadow.windows_def        = 48'hFF00_FF00_FF00;
    cfg_shadow.scales_one_to_four = {4{16'h0100}};
    cfg_shadow.scale_five         = 16'h0100;
    cfg_shadow.color_factors      = 64'h0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_fold_and_color();
    test_multipliers();
    test_register_writes();
    test_random_phases();
    test_backpressure();
    drain_pipe();

    $display("Covered %0d points: directed corners, %0d random setups, one long output stall.",
             points_sent, NumPhases);
    $display("Checked %0d result beats (%0d saturated) across %0d register writes.",
             results_seen, sat_seen, cfg_writes);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("[tglad_fold_4d_transform] OK");
    end else begin
      $display("[tglad_fold_4d_transform] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/tglad_pkg.sv
design/tglad_fold.sv
design/tglad_scale.sv
design/tglad_fold_4d_transform.sv
tb/tglad_fold_4d_transform_tb.sv
